>>> rtl/pim_pkg.sv
// ----------------------------------------------------------------------------
// pim_pkg
// Shared constants for the pair invariant mass pipeline.
// ----------------------------------------------------------------------------
package pim_pkg;

  localparam int MOMENTUM_BITS_DEF = 20;
  localparam int MASS_BITS         = 19;
  localparam int FRAC_BITS         = 11;
  localparam int PAIR_MASS_W       = 21;
  localparam logic [PAIR_MASS_W-1:0] PAIR_MASS_MAX = '1;

endpackage
// ----------------------------------------------------------------------------

>>> rtl/pim_if.sv
// ----------------------------------------------------------------------------
// pim_in_if / pim_out_if
// Valid/ready channels carrying the particle pair and the mass result.
// ----------------------------------------------------------------------------
interface pim_in_if #(parameter int MOMENTUM_BITS = pim_pkg::MOMENTUM_BITS_DEF);
  logic                                valid;
  logic                                ready;
  logic signed [MOMENTUM_BITS-1:0]     ax_momentum;
  logic signed [MOMENTUM_BITS-1:0]     ay_momentum;
  logic signed [MOMENTUM_BITS-1:0]     az_momentum;
  logic        [pim_pkg::MASS_BITS-1:0] a_rest_mass;
  logic signed [MOMENTUM_BITS-1:0]     bx_momentum;
  logic signed [MOMENTUM_BITS-1:0]     by_momentum;
  logic signed [MOMENTUM_BITS-1:0]     bz_momentum;
  logic        [pim_pkg::MASS_BITS-1:0] b_rest_mass;

  modport source (output valid, ax_momentum, ay_momentum, az_momentum, a_rest_mass,
                  bx_momentum, by_momentum, bz_momentum, b_rest_mass, input ready);
  modport sink   (input valid, ax_momentum, ay_momentum, az_momentum, a_rest_mass,
                  bx_momentum, by_momentum, bz_momentum, b_rest_mass, output ready);
endinterface

interface pim_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [pim_pkg::PAIR_MASS_W-1:0]       pair_mass;
  logic                                  negative_clamped;

  modport source (output valid, pair_mass, negative_clamped, input ready);
  modport sink   (input valid, pair_mass, negative_clamped, output ready);
endinterface
// ----------------------------------------------------------------------------

>>> rtl/pim_sqrt.sv
// ----------------------------------------------------------------------------
// pim_sqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module pim_sqrt #(
  parameter int IN_W   = 64,
  parameter int SIDE_W = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  logic [IN_W-1:0]     x_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                vld_o,
  output logic [IN_W/2-1:0]   root_o,
  output logic [SIDE_W-1:0]   side_o
);

  localparam int RES_W = IN_W / 2;
  localparam int RW    = RES_W + 2;

  logic                vld_q  [RES_W];
  logic [IN_W-1:0]     x_q    [RES_W];
  logic [RW-1:0]       rem_q  [RES_W];
  logic [RES_W-1:0]    root_q [RES_W];
  logic [SIDE_W-1:0]   side_q [RES_W];

  for (genvar k = 0; k < RES_W; k++) begin : g_stage
    logic              vld_in;
    logic [IN_W-1:0]   x_in;
    logic [RW-1:0]     rem_in;
    logic [RES_W-1:0]  root_in;
    logic [SIDE_W-1:0] side_in;
    logic [RW-1:0]     shifted;
    logic [RW-1:0]     trial;
    logic              fits;

    if (k == 0) begin : g_first
      assign vld_in  = vld_i;
      assign x_in    = x_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign x_in    = x_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    // bring down the next two bits, try root*4+1
    assign shifted = {rem_in[RW-3:0], x_in[IN_W-1 -: 2]};
    assign trial   = {root_in, 2'b01};
    assign fits    = shifted >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]    <= {x_in[IN_W-3:0], 2'b00};
        rem_q[k]  <= fits ? shifted - trial : shifted;
        root_q[k] <= {root_in[RES_W-2:0], fits};
        side_q[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[RES_W-1];
  assign root_o = root_q[RES_W-1];
  assign side_o = side_q[RES_W-1];

endmodule
// ----------------------------------------------------------------------------

>>> rtl/pair_invariant_mass_top.sv
// ----------------------------------------------------------------------------
// pair_invariant_mass_top
// Invariant mass of a particle pair, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one word per pair: three signed momenta and a rest mass for
//   each particle, in MeV. out_o returns one word per pair: floor of the pair
//   mass in MeV, saturated at PAIR_MASS_MAX, and a flag set when the squared
//   mass fell below zero. EW, the energy root width, is 32 at the default
//   momentum width. One word enters per cycle while the receiver takes
//   results; the two energy roots and the final root are bit-per-stage
//   pipelines, one stage per result bit.
//   A stalled receiver freezes the whole pipeline, the output word holds and
//   in_i.ready drops until the output is taken; nothing is lost or repeated.
//   Reset clears all valid bits; the pipeline is empty and ready after it.
// ----------------------------------------------------------------------------
module pair_invariant_mass_top #(
  parameter int MOMENTUM_BITS = pim_pkg::MOMENTUM_BITS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  pim_in_if.sink    in_i,
  pim_out_if.source out_o
);
  import pim_pkg::*;

  localparam int MB   = MOMENTUM_BITS;
  localparam int M2W  = 2 * MASS_BITS;
  localparam int P2W  = 2 * MB;
  localparam int SW   = ((P2W > M2W) ? P2W : M2W) + 1;
  localparam int EIN0 = SW + 2 * FRAC_BITS;
  localparam int EIN  = EIN0 + (EIN0 % 2);
  localparam int EW   = EIN / 2;
  localparam int ESW  = EW + 1;
  localparam int E2W  = 2 * ESW;
  localparam int SMW  = MB + 1;
  localparam int SQW  = 2 * SMW;
  localparam int PSW  = SQW + 2;
  localparam int PW   = PSW + 2 * FRAC_BITS;
  localparam int DW   = (E2W > PW) ? E2W : PW;
  localparam int RW   = E2W / 2;
  localparam int MW   = RW - FRAC_BITS;
  localparam int CW   = (MW > PAIR_MASS_W) ? MW : PAIR_MASS_W;

  logic en;
  logic out_vld_q;

  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // stage 1: squares and momentum sums
  logic signed [SMW-1:0] sx, sy, sz;
  logic [MB-1:0] amx, amy, amz, bmx, bmy, bmz;

  assign amx = in_i.ax_momentum[MB-1] ? MB'(-in_i.ax_momentum) : MB'(in_i.ax_momentum);
  assign amy = in_i.ay_momentum[MB-1] ? MB'(-in_i.ay_momentum) : MB'(in_i.ay_momentum);
  assign amz = in_i.az_momentum[MB-1] ? MB'(-in_i.az_momentum) : MB'(in_i.az_momentum);
  assign bmx = in_i.bx_momentum[MB-1] ? MB'(-in_i.bx_momentum) : MB'(in_i.bx_momentum);
  assign bmy = in_i.by_momentum[MB-1] ? MB'(-in_i.by_momentum) : MB'(in_i.by_momentum);
  assign bmz = in_i.bz_momentum[MB-1] ? MB'(-in_i.bz_momentum) : MB'(in_i.bz_momentum);
  assign sx  = SMW'(in_i.ax_momentum) + SMW'(in_i.bx_momentum);
  assign sy  = SMW'(in_i.ay_momentum) + SMW'(in_i.by_momentum);
  assign sz  = SMW'(in_i.az_momentum) + SMW'(in_i.bz_momentum);

  logic           s1_vld_q;
  logic [M2W-1:0] am2_q, bm2_q;
  logic [P2W-1:0] ax2_q, ay2_q, az2_q, bx2_q, by2_q, bz2_q;
  logic [SMW-1:0] sxm_q, sym_q, szm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      am2_q <= M2W'(in_i.a_rest_mass) * M2W'(in_i.a_rest_mass);
      bm2_q <= M2W'(in_i.b_rest_mass) * M2W'(in_i.b_rest_mass);
      ax2_q <= P2W'(amx) * P2W'(amx);
      ay2_q <= P2W'(amy) * P2W'(amy);
      az2_q <= P2W'(amz) * P2W'(amz);
      bx2_q <= P2W'(bmx) * P2W'(bmx);
      by2_q <= P2W'(bmy) * P2W'(bmy);
      bz2_q <= P2W'(bmz) * P2W'(bmz);
      sxm_q <= sx[SMW-1] ? SMW'(-sx) : SMW'(sx);
      sym_q <= sy[SMW-1] ? SMW'(-sy) : SMW'(sy);
      szm_q <= sz[SMW-1] ? SMW'(-sz) : SMW'(sz);
    end
  end

  // stage 2: m^2 + |p|^2 per particle
  logic           s2_vld_q;
  logic [SW-1:0]  sa_q, sb_q;
  logic [SMW-1:0] s2_sxm_q, s2_sym_q, s2_szm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_q     <= SW'(am2_q) + SW'(ax2_q) + SW'(ay2_q) + SW'(az2_q);
      sb_q     <= SW'(bm2_q) + SW'(bx2_q) + SW'(by2_q) + SW'(bz2_q);
      s2_sxm_q <= sxm_q;
      s2_sym_q <= sym_q;
      s2_szm_q <= szm_q;
    end
  end

  // energy roots; pair momentum rides along split over both
  logic             ea_vld, eb_vld;
  logic [EW-1:0]    ea, eb;
  logic [2*SMW-1:0] side_a;
  logic [SMW-1:0]   side_b;

  pim_sqrt #(.IN_W(EIN), .SIDE_W(2 * SMW)) u_sqrt_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s2_vld_q),
    .x_i    (EIN'(sa_q) << (2 * FRAC_BITS)),
    .side_i ({s2_sxm_q, s2_sym_q}),
    .vld_o  (ea_vld),
    .root_o (ea),
    .side_o (side_a)
  );

  pim_sqrt #(.IN_W(EIN), .SIDE_W(SMW)) u_sqrt_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s2_vld_q),
    .x_i    (EIN'(sb_q) << (2 * FRAC_BITS)),
    .side_i (s2_szm_q),
    .vld_o  (eb_vld),
    .root_o (eb),
    .side_o (side_b)
  );

  // stage E1: energy sum, pair momentum squares
  logic           e1_vld_q;
  logic [ESW-1:0] esum_q;
  logic [SQW-1:0] sx2_q, sy2_q, sz2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_vld_q <= 1'b0;
    end else if (en) begin
      e1_vld_q <= ea_vld && eb_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      esum_q <= ESW'(ea) + ESW'(eb);
      sx2_q  <= SQW'(side_a[2*SMW-1:SMW]) * SQW'(side_a[2*SMW-1:SMW]);
      sy2_q  <= SQW'(side_a[SMW-1:0]) * SQW'(side_a[SMW-1:0]);
      sz2_q  <= SQW'(side_b) * SQW'(side_b);
    end
  end

  // stage E2: (E1+E2)^2 and |p1+p2|^2
  logic           e2_vld_q;
  logic [E2W-1:0] e2_q;
  logic [PSW-1:0] p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e2_vld_q <= 1'b0;
    end else if (en) begin
      e2_vld_q <= e1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e2_q <= E2W'(esum_q) * E2W'(esum_q);
      p2_q <= PSW'(sx2_q) + PSW'(sy2_q) + PSW'(sz2_q);
    end
  end

  // stage E3: squared mass, clamp when negative
  logic [DW-1:0]  e2_ext, p2_ext;
  logic           e3_vld_q;
  logic           e3_neg_q;
  logic [E2W-1:0] d_q;

  assign e2_ext = DW'(e2_q);
  assign p2_ext = DW'(p2_q) << (2 * FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e3_vld_q <= 1'b0;
    end else if (en) begin
      e3_vld_q <= e2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e3_neg_q <= p2_ext > e2_ext;
      d_q      <= (p2_ext > e2_ext) ? '0 : E2W'(e2_ext - p2_ext);
    end
  end

  // final root
  logic          m_vld;
  logic [RW-1:0] m_root;
  logic          m_neg;

  pim_sqrt #(.IN_W(E2W), .SIDE_W(1)) u_sqrt_m (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (e3_vld_q),
    .x_i    (d_q),
    .side_i (e3_neg_q),
    .vld_o  (m_vld),
    .root_o (m_root),
    .side_o (m_neg)
  );

  // output word: drop fraction, saturate
  logic [MW-1:0] mass_full;
  logic [CW-1:0] mass_cmp;

  assign mass_full = m_root[RW-1:FRAC_BITS];
  assign mass_cmp  = CW'(mass_full);

  logic [PAIR_MASS_W-1:0] mass_q;
  logic                   neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= m_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mass_q <= (mass_cmp > CW'(PAIR_MASS_MAX)) ? PAIR_MASS_MAX : PAIR_MASS_W'(mass_cmp);
      neg_q  <= m_neg;
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.pair_mass        = mass_q;
  assign out_o.negative_clamped = neg_q;

endmodule
// ----------------------------------------------------------------------------
